@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/stbs_pkg.sv @@
package stbs_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int KEY_W = 32;
  localparam int POS_W = 10;
  localparam int CNT_W = 11;
  localparam int Q_DEPTH = 2;

  // action codes on the input port
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_FIND  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_CLEAR,
    OP_FIND,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
  } item_t;

endpackage

@@ rtl/stbs_front.sv @@
module stbs_front
  import stbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       action,
  input  logic [KEY_W-1:0] key,
  output logic             push_valid,
  input  logic             push_ready,
  output item_t            push_item
);

  logic  held;
  item_t item;
  op_t   op_dec;

  // decode the action code, unused code becomes a no-op
  always_comb begin
    unique case (action)
      ACT_LOAD:  op_dec = OP_LOAD;
      ACT_CLEAR: op_dec = OP_CLEAR;
      ACT_FIND:  op_dec = OP_FIND;
      default:   op_dec = OP_NOP;
    endcase
  end

  assign in_ready   = !held || push_ready;
  assign push_valid = held;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.op  <= op_dec;
      item.key <= key;
    end
  end

endmodule

@@ rtl/stbs_queue.sv @@
`include "assert_macros.svh"

module stbs_queue
  import stbs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int NW = $clog2(Q_DEPTH + 1);

  item_t         slots [Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != NW'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= NW'(Q_DEPTH), "queue count above depth")
  `ASSERT_IMPL(a_ptr_sync, count == '0, wr_ptr == rd_ptr, "empty queue with pointers apart")
  `ASSERT_NEXT(a_pop_drains, do_pop && !do_push, count == $past(count) - NW'(1), "pop lost")

endmodule

@@ rtl/stbs_back.sv @@
`include "assert_macros.svh"

module stbs_back
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  localparam int IW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  item_t            pop_item,
  output logic             res_valid,
  input  logic             res_ready,
  output logic             res_found,
  output logic [IW-1:0]    res_pos,
  output logic [CW-1:0]    res_cnt,
  output logic [1:0]       res_status
);

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  state_t           state;
  logic [CW-1:0]    fill;
  logic [KEY_W-1:0] last_key;
  logic [KEY_W-1:0] key_q;
  logic [CW-1:0]    lo;
  logic [CW-1:0]    hi;
  logic [IW-1:0]    mid;

  logic [KEY_W-1:0] mem [TABLE_DEPTH];
  logic [KEY_W-1:0] rd_data;

  logic             slot_free;
  logic             start_search;
  logic             load_full;
  logic             load_order;
  logic             load_ok;
  logic             mem_we;
  logic             rd_en;
  logic             hit;
  logic             finish;
  logic             res_set;
  logic [CW-1:0]    lo_n;
  logic [CW-1:0]    hi_n;
  logic [CW-1:0]    span;
  logic [IW-1:0]    mid_n;

  assign slot_free    = !res_valid || res_ready;
  assign load_full    = (fill == CW'(TABLE_DEPTH));
  assign load_order   = (fill != '0) && (pop_item.key <= last_key);
  assign load_ok      = !load_full && !load_order;
  assign start_search = (state == S_IDLE) && pop_valid && (pop_item.op == OP_FIND)
                        && (fill != '0);
  assign pop_ready    = (state == S_IDLE) && (slot_free || start_search);
  assign mem_we       = pop_valid && pop_ready && (pop_item.op == OP_LOAD) && load_ok;

  // a new result enters the output register this cycle
  assign res_set = ((state == S_IDLE) && pop_valid && pop_ready && !start_search)
                   || ((state == S_SEARCH) && finish && slot_free);

  // bounds are half open: [lo, hi)
  always_comb begin
    hit  = 1'b0;
    lo_n = lo;
    hi_n = hi;
    if (state == S_IDLE) begin
      lo_n = '0;
      hi_n = fill;
    end else begin
      priority if (rd_data < key_q) begin
        lo_n = CW'(mid) + CW'(1);
      end else if (rd_data > key_q) begin
        hi_n = CW'(mid);
      end else begin
        hit = 1'b1;
      end
    end
    finish = hit || (lo_n >= hi_n);
    span   = hi_n - lo_n - CW'(1);
    mid_n  = IW'(lo_n + (span >> 1));
    rd_en  = start_search || ((state == S_SEARCH) && !finish);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill[IW-1:0]] <= pop_item.key;
    end
    if (rd_en) begin
      rd_data <= mem[mid_n];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_set || (res_valid && !res_ready);
      unique case (state)
        S_IDLE: begin
          if (pop_valid && pop_ready) begin
            if (start_search) begin
              key_q <= pop_item.key;
              lo    <= lo_n;
              hi    <= hi_n;
              mid   <= mid_n;
              state <= S_SEARCH;
            end else begin
              res_found <= 1'b0;
              unique case (pop_item.op)
                OP_LOAD: begin
                  if (load_full) begin
                    res_pos    <= '0;
                    res_cnt    <= fill;
                    res_status <= ST_FULL;
                  end else if (load_order) begin
                    res_pos    <= '0;
                    res_cnt    <= fill;
                    res_status <= ST_ORDER;
                  end else begin
                    res_pos    <= fill[IW-1:0];
                    res_cnt    <= fill + CW'(1);
                    res_status <= ST_OK;
                    fill       <= fill + CW'(1);
                    last_key   <= pop_item.key;
                  end
                end
                OP_CLEAR: begin
                  res_pos    <= '0;
                  res_cnt    <= '0;
                  res_status <= ST_OK;
                  fill       <= '0;
                end
                default: begin
                  res_pos    <= '0;
                  res_cnt    <= fill;
                  res_status <= ST_OK;
                end
              endcase
            end
          end
        end
        S_SEARCH: begin
          if (finish) begin
            if (slot_free) begin
              res_found  <= hit;
              res_pos    <= hit ? mid : '0;
              res_cnt    <= fill;
              res_status <= ST_OK;
              state      <= S_IDLE;
            end
          end else begin
            lo  <= lo_n;
            hi  <= hi_n;
            mid <= mid_n;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_fill_bound, fill <= CW'(TABLE_DEPTH), "entry count above table depth")
  `ASSERT_IMPL(a_bounds_open, state == S_SEARCH, lo < hi, "search with empty bounds")
  `ASSERT_IMPL(a_found_ok, res_valid && res_found, res_status == ST_OK, "hit with error status")

endmodule

@@ rtl/sorted_table_binary_search.sv @@
// sorted id table with binary search lookup
// input channel (in_valid / in_ready) carries one transaction: action and key.
//   action load appends key to the table, clear empties it, find looks it up;
//   the unused action code changes nothing and still answers.
// output channel (out_valid / out_ready) returns exactly one result per input
//   transaction, in order: found, position, entry_count and status.
// datapath: a front register, a two-entry queue and the execution unit sit in
//   the path of every transaction; a find also runs a binary search over the
//   filled part of the table before its result is registered.
// throughput: load and clear run one per cycle while out_ready is high; a find
//   holds the execution unit for an issue step, then its probes in turn, set by
//   the single read port of the id memory (one registered read per cycle).
// reset: the table is empty and all channels idle; the id memory itself is not
//   cleared, entries are only read below the fill count.
// stall: a finished result waits in the output register; the execution unit
//   stops before overwriting it, the queue and front register fill up and then
//   in_ready drops. no transaction is lost or repeated.
module sorted_table_binary_search
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       action,
  input  logic [KEY_W-1:0] key,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             found,
  output logic [POS_W-1:0] position,
  output logic [CNT_W-1:0] entry_count,
  output logic [1:0]       status
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // front to queue
  logic  push_valid;
  logic  push_ready;
  item_t push_item;

  // queue to execution unit
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  // execution unit result, native widths
  logic          res_found;
  logic [IW-1:0] res_pos;
  logic [CW-1:0] res_cnt;
  logic [1:0]    res_status;

  // zero-extended copies so the port widths can be cut from them
  logic [IW+POS_W-1:0] pos_ext;
  logic [CW+CNT_W-1:0] cnt_ext;

  stbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .key        (key),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  stbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  stbs_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res_found  (res_found),
    .res_pos    (res_pos),
    .res_cnt    (res_cnt),
    .res_status (res_status)
  );

  // position and count are masked to the port widths for any table depth
  assign pos_ext     = {{POS_W{1'b0}}, res_pos};
  assign cnt_ext     = {{CNT_W{1'b0}}, res_cnt};
  assign found       = res_found;
  assign position    = pos_ext[POS_W-1:0];
  assign entry_count = cnt_ext[CNT_W-1:0];
  assign status      = res_status;

endmodule
